// ----- hw/rtl/ssfb_pkg.sv -----
// Shared types, command codes and segment constants of the seven-segment frame builder.
package ssfb_pkg;

  localparam int DIGIT_COUNT_DEF = 10;
  localparam int FRAME_BYTES_DEF = 12;
  localparam int QUEUE_DEPTH     = 2;

  localparam logic [7:0] SEG_POINT = 8'h10;
  localparam logic [7:0] FLAG_ERR  = 8'h10;
  localparam logic [7:0] FLAG_MEM  = 8'h40;
  localparam logic [7:0] FLAG_NEG  = 8'h20;
  localparam logic [7:0] FLAG_SEP3 = 8'h01;
  localparam logic [7:0] SEP_ONE   = 8'h01;
  localparam logic [7:0] SEP_TWO   = 8'h11;

  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  localparam logic [3:0] KIND_CHAR  = 4'd0;
  localparam logic [3:0] KIND_END   = 4'd1;
  localparam logic [3:0] KIND_DIGIT = 4'd2;
  localparam logic [3:0] KIND_POINT = 4'd3;
  localparam logic [3:0] KIND_ERR   = 4'd4;
  localparam logic [3:0] KIND_MEM   = 4'd5;
  localparam logic [3:0] KIND_SEP   = 4'd6;
  localparam logic [3:0] KIND_FILL  = 4'd7;
  localparam logic [3:0] KIND_SEND  = 4'd8;

  localparam logic [3:0] OP_NONE  = 4'd0;
  localparam logic [3:0] OP_CHAR  = 4'd1;
  localparam logic [3:0] OP_END   = 4'd2;
  localparam logic [3:0] OP_DIGIT = 4'd3;
  localparam logic [3:0] OP_POINT = 4'd4;
  localparam logic [3:0] OP_ERR   = 4'd5;
  localparam logic [3:0] OP_MEM   = 4'd6;
  localparam logic [3:0] OP_SEP   = 4'd7;
  localparam logic [3:0] OP_FILL  = 4'd8;
  localparam logic [3:0] OP_SEND  = 4'd9;

  localparam logic [2:0] CLS_POINT = 3'd0;
  localparam logic [2:0] CLS_STOP  = 3'd1;
  localparam logic [2:0] CLS_BLANK = 3'd2;
  localparam logic [2:0] CLS_DIGIT = 3'd3;
  localparam logic [2:0] CLS_BAD   = 3'd4;

  localparam logic [1:0] MODE_NORMAL   = 2'd0;
  localparam logic [1:0] MODE_STOPPED  = 2'd1;
  localparam logic [1:0] MODE_REJECTED = 2'd2;

  typedef struct packed {
    logic [3:0]        kind;
    logic [7:0]        char_code;
    logic [7:0]        position;
    logic signed [7:0] digit_value;
    logic              flag_value;
    logic [7:0]        group_count;
    logic [2:0]        group_shift;
    logic [7:0]        fill_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic [3:0] byte_index;
    logic       last;
    logic       status;
  } out_item_t;

  typedef struct packed {
    logic [3:0] op;
    logic [2:0] cls;
    logic       flag;
    logic [7:0] pos;
    logic [7:0] data;
  } cmd_t;

  function automatic logic [7:0] seg_of(input logic [3:0] d);
    logic [7:0] s;
    unique case (d)
      4'd0:    s = 8'hEB;
      4'd1:    s = 8'h60;
      4'd2:    s = 8'hC7;
      4'd3:    s = 8'hE5;
      4'd4:    s = 8'h6C;
      4'd5:    s = 8'hAD;
      4'd6:    s = 8'hAF;
      4'd7:    s = 8'hE0;
      4'd8:    s = 8'hEF;
      4'd9:    s = 8'hED;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage

// ----- hw/rtl/ssfb_front.sv -----
// Front end: takes items, decodes them into commands and drops those that do nothing.
module ssfb_front #(
  parameter int DIGIT_COUNT = ssfb_pkg::DIGIT_COUNT_DEF
) (
  input  logic               start,
  output logic               busy,
  input  ssfb_pkg::in_item_t in_item,
  input  logic               q_full,
  output logic               q_push,
  output ssfb_pkg::cmd_t     q_cmd
);
  import ssfb_pkg::*;

  logic       pos_ok;
  logic [7:0] c;

  assign busy   = q_full;
  assign c      = in_item.char_code;
  assign pos_ok = {24'd0, in_item.position} < DIGIT_COUNT;

  always_comb begin
    q_cmd      = '0;
    q_cmd.pos  = in_item.position;
    unique case (in_item.kind)
      KIND_CHAR: begin
        q_cmd.op   = OP_CHAR;
        q_cmd.flag = (c == CH_MINUS);
        priority if (c == CH_POINT) begin
          q_cmd.cls = CLS_POINT;
        end else if (c == 8'd0 || c[7]) begin
          q_cmd.cls = CLS_STOP;
        end else if (c == CH_SPACE) begin
          q_cmd.cls = CLS_BLANK;
        end else if (c >= CH_ZERO && c <= CH_NINE) begin
          q_cmd.cls  = CLS_DIGIT;
          q_cmd.data = seg_of(4'(c - CH_ZERO));
        end else begin
          q_cmd.cls = CLS_BAD;
        end
      end
      KIND_END: q_cmd.op = OP_END;
      KIND_DIGIT: begin
        q_cmd.op   = pos_ok ? OP_DIGIT : OP_NONE;
        q_cmd.flag = ($unsigned(in_item.digit_value) <= 8'd9);
        q_cmd.data = seg_of(in_item.digit_value[3:0]);
      end
      KIND_POINT: q_cmd.op = pos_ok ? OP_POINT : OP_NONE;
      KIND_ERR: begin
        q_cmd.op   = OP_ERR;
        q_cmd.flag = in_item.flag_value;
      end
      KIND_MEM: begin
        q_cmd.op   = OP_MEM;
        q_cmd.flag = in_item.flag_value;
      end
      KIND_SEP: begin
        q_cmd.op   = (in_item.group_count <= 8'd3) ? OP_SEP : OP_NONE;
        q_cmd.flag = (in_item.group_count == 8'd3);
        if (in_item.group_count == 8'd1) begin
          q_cmd.data = SEP_ONE << in_item.group_shift;
        end else if (in_item.group_count != 8'd0) begin
          q_cmd.data = SEP_TWO << in_item.group_shift;
        end
      end
      KIND_FILL: begin
        q_cmd.op   = OP_FILL;
        q_cmd.data = in_item.fill_byte;
      end
      KIND_SEND: q_cmd.op = OP_SEND;
      default:   q_cmd.op = OP_NONE;
    endcase
  end

  assign q_push = start && !q_full && (q_cmd.op != OP_NONE);

endmodule

// ----- hw/rtl/ssfb_queue.sv -----
// Short command queue between the front end and the frame engine.
module ssfb_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ssfb_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           valid,
  output ssfb_pkg::cmd_t head
);
  import ssfb_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign valid = (count_r != '0);
  assign head  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ----- hw/rtl/ssfb_back.sv -----
// Frame engine: holds the frame and the text staging, executes commands and sends frames.
module ssfb_back #(
  parameter int DIGIT_COUNT = ssfb_pkg::DIGIT_COUNT_DEF,
  parameter int FRAME_BYTES = ssfb_pkg::FRAME_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  ssfb_pkg::cmd_t      q_cmd,
  output logic                q_pop,
  output logic                out_valid,
  output ssfb_pkg::out_item_t out_item
);
  import ssfb_pkg::*;

  localparam int SEP_IDX  = DIGIT_COUNT;
  localparam int FLAG_IDX = DIGIT_COUNT + 1;
  localparam int FULL     = (FRAME_BYTES > DIGIT_COUNT + 2) ? FRAME_BYTES : DIGIT_COUNT + 2;
  localparam int LEN_W    = $clog2(DIGIT_COUNT + 1);
  localparam int IDX_W    = $clog2(FRAME_BYTES);

  logic [7:0]       frame_r [FRAME_BYTES];
  logic [7:0]       cur [FULL];
  logic [7:0]       nxt [FULL];
  logic [7:0]       staging_r [DIGIT_COUNT];
  logic [7:0]       staging_nxt [DIGIT_COUNT];
  logic [LEN_W-1:0] text_length_r, text_length_nxt;
  logic             text_at_start_r, text_at_start_nxt;
  logic [1:0]       text_mode_r, text_mode_nxt;
  logic             sending_r, sending_nxt;
  logic [IDX_W-1:0] send_idx_r, send_idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_item_r, out_item_nxt;
  logic [7:0]       flag_cur, flag_new;
  logic             proceed;
  logic             send_last;

  for (genvar g = 0; g < FULL; g++) begin : g_frame
    if (g < FRAME_BYTES) begin : g_reg
      assign cur[g] = frame_r[g];
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          frame_r[g] <= '0;
        end else begin
          frame_r[g] <= nxt[g];
        end
      end
    end else begin : g_none
      assign cur[g] = '0;
    end
  end

  assign send_last = (send_idx_r == IDX_W'(FRAME_BYTES - 1));
  assign q_pop     = q_valid && !sending_r;

  always_comb begin
    nxt               = cur;
    staging_nxt       = staging_r;
    text_length_nxt   = text_length_r;
    text_at_start_nxt = text_at_start_r;
    text_mode_nxt     = text_mode_r;
    sending_nxt       = sending_r;
    send_idx_nxt      = send_idx_r;
    out_valid_nxt     = 1'b0;
    out_item_nxt      = '0;
    flag_cur          = cur[FLAG_IDX];
    flag_new          = flag_cur;
    proceed           = 1'b1;

    if (sending_r) begin
      out_valid_nxt           = 1'b1;
      out_item_nxt.frame_byte = frame_r[send_idx_r];
      out_item_nxt.byte_index = 4'(send_idx_r);
      out_item_nxt.last       = send_last;
      if (send_last) begin
        sending_nxt = 1'b0;
      end else begin
        send_idx_nxt = send_idx_r + 1'b1;
      end
    end

    if (q_pop) begin
      unique case (q_cmd.op)
        OP_CHAR: begin
          if (text_at_start_r) begin
            text_at_start_nxt = 1'b0;
            flag_new = q_cmd.flag ? (flag_cur | FLAG_NEG) : (flag_cur & ~FLAG_NEG);
            proceed  = !q_cmd.flag;
          end
          if (proceed && text_mode_r == MODE_NORMAL) begin
            priority if (q_cmd.cls == CLS_POINT) begin
              for (int k = 0; k < DIGIT_COUNT; k++) begin
                if (text_length_r == LEN_W'(k + 1)) begin
                  staging_nxt[k] = staging_r[k] | SEG_POINT;
                end
              end
            end else if (q_cmd.cls == CLS_STOP || text_length_r >= LEN_W'(DIGIT_COUNT)) begin
              text_mode_nxt = MODE_STOPPED;
            end else if (q_cmd.cls == CLS_BAD) begin
              text_mode_nxt = MODE_REJECTED;
            end else begin
              for (int k = 0; k < DIGIT_COUNT; k++) begin
                if (text_length_r == LEN_W'(k)) begin
                  staging_nxt[k] = q_cmd.data;
                end
              end
              text_length_nxt = text_length_r + 1'b1;
            end
          end
        end
        OP_END: begin
          if (text_at_start_r) begin
            flag_new = flag_cur & ~FLAG_NEG;
          end
          text_length_nxt   = '0;
          text_at_start_nxt = 1'b1;
          text_mode_nxt     = MODE_NORMAL;
          if (text_mode_r == MODE_REJECTED) begin
            out_valid_nxt     = 1'b1;
            out_item_nxt.last   = 1'b1;
            out_item_nxt.status = 1'b1;
          end else begin
            for (int j = 0; j < DIGIT_COUNT; j++) begin
              nxt[j] = (int'(text_length_r) >= DIGIT_COUNT - j) ?
                       staging_r[DIGIT_COUNT - 1 - j] : 8'h00;
            end
            sending_nxt  = 1'b1;
            send_idx_nxt = '0;
          end
        end
        OP_DIGIT: begin
          for (int j = 0; j < DIGIT_COUNT; j++) begin
            if (q_cmd.pos == 8'(j)) begin
              nxt[j] = q_cmd.flag ? ((cur[j] & SEG_POINT) | q_cmd.data) : 8'h00;
            end
          end
        end
        OP_POINT: begin
          for (int j = 0; j < DIGIT_COUNT; j++) begin
            nxt[j] = (cur[j] & ~SEG_POINT) | ((q_cmd.pos == 8'(j)) ? SEG_POINT : 8'h00);
          end
        end
        OP_ERR: flag_new = q_cmd.flag ? (flag_cur | FLAG_ERR) : (flag_cur & ~FLAG_ERR);
        OP_MEM: flag_new = q_cmd.flag ? (flag_cur | FLAG_MEM) : (flag_cur & ~FLAG_MEM);
        OP_SEP: begin
          nxt[SEP_IDX] = q_cmd.data;
          flag_new = q_cmd.flag ? (flag_cur | FLAG_SEP3) : (flag_cur & ~FLAG_SEP3);
        end
        OP_FILL: begin
          for (int j = 0; j < FULL; j++) begin
            nxt[j] = q_cmd.data;
          end
          flag_new = q_cmd.data;
        end
        OP_SEND: begin
          sending_nxt  = 1'b1;
          send_idx_nxt = '0;
        end
        default: ;
      endcase
    end

    nxt[FLAG_IDX] = flag_new;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_length_r   <= '0;
      text_at_start_r <= 1'b1;
      text_mode_r     <= MODE_NORMAL;
      sending_r       <= 1'b0;
      send_idx_r      <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      text_length_r   <= text_length_nxt;
      text_at_start_r <= text_at_start_nxt;
      text_mode_r     <= text_mode_nxt;
      sending_r       <= sending_nxt;
      send_idx_r      <= send_idx_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    staging_r  <= staging_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ----- hw/rtl/seven_segment_frame_builder_top.sv -----
// Top level of the seven-segment frame builder: front end, command queue and frame engine.
// An item is taken into the queue and executed from its head while no frame is being sent.
// Commands without a result only change the engine state; a frame send streams FRAME_BYTES
// results, one per cycle, from the send state via the output register; a rejected text gives
// one result. The engine's byte-by-byte send sets the throughput; busy rises when the queue
// is full. Reset clears the frame, the text state and the queue; no result is ever held off.
module seven_segment_frame_builder_top #(
  parameter int DIGIT_COUNT = ssfb_pkg::DIGIT_COUNT_DEF,
  parameter int FRAME_BYTES = ssfb_pkg::FRAME_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  ssfb_pkg::in_item_t  in_item,
  output logic                out_valid,
  output ssfb_pkg::out_item_t out_item
);
  import ssfb_pkg::*;

  cmd_t push_cmd;
  cmd_t head_cmd;
  logic q_push;
  logic q_full;
  logic q_valid;
  logic q_pop;

  ssfb_front #(
    .DIGIT_COUNT(DIGIT_COUNT)
  ) u_front (
    .start   (start),
    .busy    (busy),
    .in_item (in_item),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_cmd   (push_cmd)
  );

  ssfb_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (head_cmd)
  );

  ssfb_back #(
    .DIGIT_COUNT(DIGIT_COUNT),
    .FRAME_BYTES(FRAME_BYTES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (head_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// ----- bench/tb_seven_segment_frame_builder_top.sv -----
// Self-checking bench for the seven-segment frame builder: directed table, random texts and commands.
module tb_seven_segment_frame_builder_top;
  import ssfb_pkg::*;

  localparam int DIGITS   = DIGIT_COUNT_DEF;
  localparam int FRAME_N  = FRAME_BYTES_DEF;
  localparam int SEP_IDX  = DIGITS;
  localparam int FLAG_IDX = DIGITS + 1;

  localparam int RANDOM_ITEMS = 460;
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 20;
  localparam int REPORT_MAX   = 10;

  localparam logic STATUS_SENT   = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;
  localparam logic [3:0] KIND_TOP = 4'hF;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic [7:0] GLYPH [10] = '{8'hEB, 8'h60, 8'hC7, 8'hE5, 8'h6C,
                                       8'hAD, 8'hAF, 8'hE0, 8'hEF, 8'hED};

  typedef struct {
    int unsigned count;
    logic [7:0]  fill;
  } fixed_frame_t;

  typedef struct {
    in_item_t     item;
    fixed_frame_t fixed;
  } directed_row_t;

  logic      clk;
  logic      rst_n   = 1'b0;
  logic      start   = 1'b0;
  in_item_t  in_item = '0;
  logic      busy;
  logic      out_valid;
  out_item_t out_item;

  seven_segment_frame_builder_top DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  logic [7:0]  frame_img [FRAME_N];
  logic [7:0]  staged [DIGITS];
  int unsigned txt_len;
  bit          txt_first;
  logic [1:0]  txt_mode;

  out_item_t     pending_bytes[$];
  out_item_t     fresh_bytes[$];
  fixed_frame_t  fixed_q[$];
  directed_row_t directed_rows[$];

  int unsigned burst_left;
  int unsigned commands_sent;
  int unsigned items_taken;
  int unsigned bytes_checked;
  int unsigned texts_closed;
  int unsigned texts_rejected;
  int unsigned mismatches;
  int unsigned idle_cycles;

  task automatic set_flag(input logic [7:0] mask, input bit on);
    if (on) frame_img[FLAG_IDX] = frame_img[FLAG_IDX] | mask;
    else frame_img[FLAG_IDX] = frame_img[FLAG_IDX] & ~mask;
  endtask

  task automatic emit_frame();
    out_item_t r;
    for (int i = 0; i < FRAME_N; i++) begin
      r.frame_byte = frame_img[i];
      r.byte_index = 4'(i);
      r.last       = (i == FRAME_N - 1);
      r.status     = STATUS_SENT;
      fresh_bytes.push_back(r);
    end
  endtask

  task automatic take_char(input logic [7:0] c);
    if (txt_first) begin
      txt_first = 1'b0;
      set_flag(FLAG_NEG, c == CH_MINUS);
      if (c == CH_MINUS) return;
    end
    if (txt_mode != MODE_NORMAL) return;
    if (c == CH_POINT) begin
      if (txt_len > 0) staged[txt_len - 1] = staged[txt_len - 1] | SEG_POINT;
      return;
    end
    if (c == CH_NUL || c[7] || txt_len >= DIGITS) begin
      txt_mode = MODE_STOPPED;
      return;
    end
    if (c == CH_SPACE) begin
      staged[txt_len] = 8'h00;
      txt_len++;
    end else if (c >= CH_ZERO && c <= CH_NINE) begin
      staged[txt_len] = GLYPH[c - CH_ZERO];
      txt_len++;
    end else begin
      txt_mode = MODE_REJECTED;
    end
  endtask

  task automatic close_text();
    out_item_t   r;
    bit          rejected;
    int unsigned len;
    rejected = (txt_mode == MODE_REJECTED);
    if (txt_first) set_flag(FLAG_NEG, 1'b0);
    len = txt_len;
    txt_len   = 0;
    txt_first = 1'b1;
    txt_mode  = MODE_NORMAL;
    texts_closed++;
    if (rejected) begin
      texts_rejected++;
      r.frame_byte = 8'h00;
      r.byte_index = 4'd0;
      r.last       = 1'b1;
      r.status     = STATUS_REJECT;
      fresh_bytes.push_back(r);
      return;
    end
    for (int i = 0; i < DIGITS; i++) frame_img[i] = 8'h00;
    for (int i = 0; i < len; i++) frame_img[DIGITS - len + i] = staged[len - i - 1];
    emit_frame();
  endtask

  task automatic apply_command(input in_item_t it);
    logic [7:0] dv;
    logic [7:0] mask;
    dv = it.digit_value;
    case (it.kind)
      KIND_CHAR: take_char(it.char_code);
      KIND_END:  close_text();
      KIND_DIGIT: begin
        if (it.position < DIGITS) begin
          if (dv <= 8'd9)
            frame_img[it.position] = (frame_img[it.position] & SEG_POINT) | GLYPH[dv];
          else
            frame_img[it.position] = 8'h00;
        end
      end
      KIND_POINT: begin
        if (it.position < DIGITS) begin
          for (int i = 0; i < DIGITS; i++) frame_img[i] = frame_img[i] & ~SEG_POINT;
          frame_img[it.position] = frame_img[it.position] | SEG_POINT;
        end
      end
      KIND_ERR: set_flag(FLAG_ERR, it.flag_value);
      KIND_MEM: set_flag(FLAG_MEM, it.flag_value);
      KIND_SEP: begin
        if (it.group_count <= 8'd3) begin
          if (it.group_count == 8'd0) mask = 8'h00;
          else if (it.group_count == 8'd1) mask = SEP_ONE << it.group_shift;
          else mask = SEP_TWO << it.group_shift;
          frame_img[SEP_IDX] = mask;
          set_flag(FLAG_SEP3, it.group_count == 8'd3);
        end
      end
      KIND_FILL: for (int i = 0; i < FRAME_N; i++) frame_img[i] = it.fill_byte;
      KIND_SEND: emit_frame();
      default: ;
    endcase
  endtask

  task automatic take_item(input in_item_t it);
    fixed_frame_t f;
    out_item_t    r;
    f = fixed_q.pop_front();
    fresh_bytes.delete();
    apply_command(it);
    if (f.count == 0) begin
      foreach (fresh_bytes[i]) pending_bytes.push_back(fresh_bytes[i]);
    end else if (f.count == 1) begin
      r.frame_byte = f.fill;
      r.byte_index = 4'd0;
      r.last       = 1'b1;
      r.status     = STATUS_REJECT;
      pending_bytes.push_back(r);
    end else begin
      for (int i = 0; i < FRAME_N; i++) begin
        r.frame_byte = f.fill;
        r.byte_index = 4'(i);
        r.last       = (i == FRAME_N - 1);
        r.status     = STATUS_SENT;
        pending_bytes.push_back(r);
      end
    end
    items_taken++;
  endtask

  task automatic check_byte(input out_item_t got);
    out_item_t want;
    if (pending_bytes.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("Unexpected frame byte: byte %02h index %0d last %0b status %0b",
                 got.frame_byte, got.byte_index, got.last, got.status);
      return;
    end
    want = pending_bytes.pop_front();
    bytes_checked++;
    if (got.frame_byte !== want.frame_byte || got.byte_index !== want.byte_index ||
        got.last !== want.last || got.status !== want.status) begin
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("Frame byte mismatch: expected %02h/%0d/%0b/%0b, got %02h/%0d/%0b/%0b",
                 want.frame_byte, want.byte_index, want.last, want.status,
                 got.frame_byte, got.byte_index, got.last, got.status);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid) check_byte(out_item);
      if (start && !busy) take_item(in_item);
      if ((start && !busy) || out_valid) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  function automatic in_item_t cmd(input logic [3:0] kind, input logic [7:0] a,
                                   input logic [7:0] b);
    logic [63:0] raw;
    in_item_t    it;
    raw = {$urandom(), $urandom()};
    it = raw[$bits(in_item_t)-1:0];
    it.kind = kind;
    case (kind)
      KIND_CHAR:  it.char_code = a;
      KIND_DIGIT: begin
        it.position    = a;
        it.digit_value = b;
      end
      KIND_POINT: it.position = a;
      KIND_ERR, KIND_MEM: it.flag_value = a[0];
      KIND_SEP: begin
        it.group_count = a;
        it.group_shift = b[2:0];
      end
      KIND_FILL: it.fill_byte = a;
      default: ;
    endcase
    return it;
  endfunction

  task automatic drive(input in_item_t it, input fixed_frame_t f);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    fixed_q.push_back(f);
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    commands_sent++;
  endtask

  task automatic drive_model(input in_item_t it);
    fixed_frame_t f;
    f.count = 0;
    f.fill  = 8'h00;
    drive(it, f);
  endtask

  task automatic add_row(input in_item_t it, input int unsigned count, input logic [7:0] fill);
    directed_row_t row;
    row.item        = it;
    row.fixed.count = count;
    row.fixed.fill  = fill;
    directed_rows.push_back(row);
  endtask

  task automatic random_text();
    int unsigned n;
    int unsigned pick;
    logic [7:0]  c;
    if ($urandom_range(1) == 1) drive_model(cmd(KIND_CHAR, CH_MINUS, 8'h00));
    n = $urandom_range(0, 12);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 60) c = CH_ZERO + 8'($urandom_range(9));
      else if (pick < 72) c = CH_SPACE;
      else if (pick < 85) c = CH_POINT;
      else if (pick < 91) c = ($urandom_range(1) == 1) ? CH_NUL : 8'($urandom_range(128, 255));
      else if (pick < 95) c = 8'($urandom_range(8'h21, 8'h7E));
      else c = 8'($urandom_range(255));
      drive_model(cmd(KIND_CHAR, c, 8'h00));
    end
    drive_model(cmd(KIND_END, 8'h00, 8'h00));
  endtask

  task automatic random_command();
    int unsigned pick;
    logic [3:0]  kind;
    logic [7:0]  a;
    logic [7:0]  b;
    pick = $urandom_range(99);
    if (pick < 85) kind = 4'($urandom_range(KIND_DIGIT, KIND_SEND));
    else if (pick < 92) kind = 4'($urandom_range(KIND_SEND + 1, KIND_TOP));
    else kind = ($urandom_range(1) == 1) ? KIND_CHAR : KIND_END;
    a = 8'($urandom_range(255));
    b = 8'($urandom_range(255));
    if (kind == KIND_DIGIT || kind == KIND_POINT) begin
      if ($urandom_range(1) == 1) a = 8'($urandom_range(DIGITS - 1));
      if ($urandom_range(9) < 6) b = 8'($urandom_range(9));
    end
    if (kind == KIND_SEP && $urandom_range(9) < 7) a = 8'($urandom_range(3));
    drive_model(cmd(kind, a, b));
  endtask

  initial begin
    for (int i = 0; i < FRAME_N; i++) frame_img[i] = 8'h00;
    for (int i = 0; i < DIGITS; i++) staged[i] = 8'h00;
    txt_len   = 0;
    txt_first = 1'b1;
    txt_mode  = MODE_NORMAL;

    add_row(cmd(KIND_SEND, 8'h00, 8'h00), FRAME_N, 8'h00);
    add_row(cmd(KIND_FILL, 8'hFF, 8'h00), 0, 8'h00);
    add_row(cmd(KIND_SEND, 8'h00, 8'h00), FRAME_N, 8'hFF);
    add_row(cmd(KIND_CHAR, CH_MINUS, 8'h00), 0, 8'h00);
    add_row(cmd(KIND_CHAR, CH_POINT, 8'h00), 0, 8'h00);
    add_row(cmd(KIND_CHAR, CH_ZERO + 8'd1, 8'h00), 0, 8'h00);
    add_row(cmd(KIND_CHAR, CH_POINT, 8'h00), 0, 8'h00);
    add_row(cmd(KIND_CHAR, CH_SPACE, 8'h00), 0, 8'h00);
    add_row(cmd(KIND_CHAR, CH_NINE, 8'h00), 0, 8'h00);
    add_row(cmd(KIND_CHAR, 8'hFF, 8'h00), 0, 8'h00);
    add_row(cmd(KIND_CHAR, CH_ZERO, 8'h00), 0, 8'h00);
    add_row(cmd(KIND_END, 8'h00, 8'h00), 0, 8'h00);
    add_row(cmd(KIND_CHAR, 8'h41, 8'h00), 0, 8'h00);
    add_row(cmd(KIND_END, 8'h00, 8'h00), 1, 8'h00);
    add_row(cmd(KIND_END, 8'h00, 8'h00), 0, 8'h00);
    add_row(cmd(KIND_DIGIT, 8'd0, 8'd9), 0, 8'h00);
    add_row(cmd(KIND_DIGIT, 8'd255, 8'h80), 0, 8'h00);
    add_row(cmd(KIND_DIGIT, 8'd9, 8'h7F), 0, 8'h00);
    add_row(cmd(KIND_POINT, 8'd3, 8'h00), 0, 8'h00);
    add_row(cmd(KIND_POINT, 8'd10, 8'h00), 0, 8'h00);
    add_row(cmd(KIND_ERR, 8'h01, 8'h00), 0, 8'h00);
    add_row(cmd(KIND_MEM, 8'h01, 8'h00), 0, 8'h00);
    add_row(cmd(KIND_SEP, 8'd3, 8'd7), 0, 8'h00);
    add_row(cmd(KIND_SEP, 8'd255, 8'd0), 0, 8'h00);
    add_row(cmd(KIND_TOP, 8'h00, 8'h00), 0, 8'h00);
    add_row(cmd(KIND_SEND, 8'h00, 8'h00), 0, 8'h00);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) drive(directed_rows[i].item, directed_rows[i].fixed);

    while (commands_sent < RANDOM_ITEMS) begin
      if ($urandom_range(99) < 45) random_text();
      else random_command();
    end
    start <= 1'b0;

    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Accepted %0d items, closed %0d texts (%0d rejected), checked %0d frame bytes.",
             items_taken, texts_closed, texts_rejected, bytes_checked);
    $display("Mismatches: %0d, expectations left over: %0d.", mismatches, pending_bytes.size());
    if (mismatches == 0 && pending_bytes.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
